FILE: hw/rtl/htpd_pkg.sv
// Shared types and character constants for the hex text profile decoder.
package htpd_pkg;

    // Result status codes
    typedef enum logic [1:0] {
        ST_DATA   = 2'd0,
        ST_BADLEN = 2'd1,
        ST_NODATA = 2'd2
    } t_status;

    // Characters the parser reacts to
    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_NL   = 8'h0A;
    localparam logic [7:0] CH_VT   = 8'h0B;
    localparam logic [7:0] CH_FF   = 8'h0C;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_A_LO = 8'h61;
    localparam logic [7:0] CH_F_LO = 8'h66;

    // Input beat as held in the input register
    typedef struct packed {
        logic [7:0] text_char;
        logic       first_char;
        logic       end_of_text;
    } t_beat;

    // One parser result; valid marks that the beat produced an output
    typedef struct packed {
        logic       valid;
        logic [7:0] decoded_byte;
        t_status    status;
        logic       last_result;
    } t_result;

endpackage

FILE: hw/rtl/htpd_in_if.sv
// Input channel: one text character per beat.
interface htpd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;
    logic       first_char;
    logic       end_of_text;

    modport source (output valid, output text_char, output first_char,
                    output end_of_text, input ready);
    modport sink   (input valid, input text_char, input first_char,
                    input end_of_text, output ready);
endinterface

FILE: hw/rtl/htpd_out_if.sv
// Output channel: one decoded byte or error result per beat.
interface htpd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] decoded_byte;
    logic [1:0] status;
    logic       last_result;

    modport source (output valid, output decoded_byte, output status,
                    output last_result, input ready);
    modport sink   (input valid, input decoded_byte, input status,
                    input last_result, output ready);
endinterface

FILE: hw/rtl/htpd_parser.sv
// Parser state machine: header scan, byte count and hex digit pairing.
module htpd_parser #(
    parameter int unsigned MAX_PROFILE_BYTES = 65536
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  htpd_pkg::t_beat  i_beat,
    output htpd_pkg::t_result o_result
);
    import htpd_pkg::*;

    localparam int CW = $clog2(MAX_PROFILE_BYTES + 1);
    localparam logic [CW+3:0] MAX_WIDE = (CW+4)'(MAX_PROFILE_BYTES);

    typedef enum logic [2:0] {
        PH_IDLE, PH_FINDNL, PH_SKIPWS, PH_PRE, PH_DIGITS, PH_TODELIM, PH_DATA
    } t_phase;

    t_phase        r_phase, n_phase;
    logic [CW-1:0] r_count_accum, n_count_accum;
    logic          r_count_ovf, n_count_ovf;
    logic [CW-1:0] r_bytes_left, n_bytes_left;
    logic          r_nibble_odd, n_nibble_odd;
    logic [3:0]    r_high_nibble, n_high_nibble;

    logic [7:0]    w_c;
    logic          w_is_digit;
    logic          w_is_hex;
    logic          w_is_delim;
    logic [3:0]    w_nib;
    logic [CW+3:0] w_acc_next;
    t_phase        w_cnt_phase;
    logic          w_do_count;
    logic          w_err;
    t_status       w_err_code;
    logic          w_have_byte;
    logic          w_last;
    logic [CW-1:0] w_bl_dec;

    assign w_c        = i_beat.text_char;
    assign w_is_delim = (w_c == CH_SP) || (w_c == CH_NL);

    // Character class and nibble value
    always_comb begin
        w_is_digit = 1'b0;
        w_is_hex   = 1'b0;
        w_nib      = 4'd0;
        if (w_c inside {[CH_0:CH_9]}) begin
            w_is_digit = 1'b1;
            w_is_hex   = 1'b1;
            w_nib      = 4'(w_c - CH_0);
        end else if (w_c inside {[CH_A_LO:CH_F_LO]}) begin
            w_is_hex = 1'b1;
            w_nib    = 4'(w_c - CH_A_LO + 8'd10);
        end
    end

    // Decimal shift-add: accum * 10 + digit
    assign w_acc_next = ({4'b0, r_count_accum} << 3) + ({4'b0, r_count_accum} << 1)
                      + (CW+4)'(w_nib);
    assign w_bl_dec   = r_bytes_left - CW'(1);

    // Next state and result
    always_comb begin
        n_phase       = r_phase;
        n_count_accum = r_count_accum;
        n_count_ovf   = r_count_ovf;
        n_bytes_left  = r_bytes_left;
        n_nibble_odd  = r_nibble_odd;
        n_high_nibble = r_high_nibble;
        w_err         = 1'b0;
        w_err_code    = ST_DATA;
        w_have_byte   = 1'b0;
        w_last        = 1'b0;
        w_cnt_phase   = (r_phase == PH_SKIPWS) ? PH_PRE : r_phase;
        w_do_count    = 1'b0;

        if (i_fire) begin
            if (i_beat.first_char) begin
                n_phase       = PH_FINDNL;
                n_count_accum = '0;
                n_count_ovf   = 1'b0;
                n_bytes_left  = '0;
                n_nibble_odd  = 1'b0;
                n_high_nibble = 4'd0;
            end else begin
                case (r_phase)
                    PH_IDLE: begin
                    end
                    PH_FINDNL: begin
                        if (w_c == CH_NUL) begin
                            w_err      = 1'b1;
                            w_err_code = ST_NODATA;
                        end else if (w_c == CH_NL) begin
                            n_phase = PH_SKIPWS;
                        end
                    end
                    PH_SKIPWS: begin
                        w_do_count = !((w_c == CH_NUL) || w_is_delim);
                        if (w_do_count) begin
                            n_phase = PH_PRE;
                        end
                    end
                    PH_PRE, PH_DIGITS, PH_TODELIM: begin
                        w_do_count = 1'b1;
                    end
                    PH_DATA: begin
                        if (w_is_hex) begin
                            if (!r_nibble_odd) begin
                                n_high_nibble = w_nib;
                                n_nibble_odd  = 1'b1;
                            end else begin
                                n_nibble_odd = 1'b0;
                                w_have_byte  = 1'b1;
                                if (r_bytes_left != '0) begin
                                    n_bytes_left = w_bl_dec;
                                end
                                if (r_bytes_left <= CW'(1)) begin
                                    w_last  = 1'b1;
                                    n_phase = PH_IDLE;
                                end
                            end
                        end else if (w_c == CH_NUL) begin
                            w_err      = 1'b1;
                            w_err_code = ST_NODATA;
                        end
                    end
                    default: begin
                    end
                endcase

                // Byte count field
                if (w_do_count) begin
                    if (w_c == CH_NUL) begin
                        w_err      = 1'b1;
                        w_err_code = ST_NODATA;
                    end else if (w_is_delim) begin
                        if (r_count_ovf || (r_count_accum == '0)) begin
                            w_err      = 1'b1;
                            w_err_code = ST_BADLEN;
                        end else begin
                            n_bytes_left = r_count_accum;
                            n_nibble_odd = 1'b0;
                            n_phase      = PH_DATA;
                        end
                    end else if (w_cnt_phase == PH_PRE || w_cnt_phase == PH_DIGITS) begin
                        if (w_is_digit) begin
                            if (!r_count_ovf) begin
                                if (w_acc_next > MAX_WIDE) begin
                                    n_count_ovf = 1'b1;
                                end else begin
                                    n_count_accum = w_acc_next[CW-1:0];
                                end
                            end
                            n_phase = PH_DIGITS;
                        end else if (w_cnt_phase == PH_DIGITS) begin
                            n_phase = PH_TODELIM;
                        end else if (w_c inside {CH_TAB, CH_VT, CH_FF, CH_CR}) begin
                            n_phase = PH_PRE;
                        end else begin
                            // sign or junk before the number: count becomes zero
                            n_count_accum = '0;
                            n_phase       = PH_TODELIM;
                        end
                    end
                end
            end

            // Text ended before decoding finished
            if (!w_err && i_beat.end_of_text && (n_phase != PH_IDLE)) begin
                w_err      = 1'b1;
                w_err_code = ST_NODATA;
            end
            if (w_err) begin
                n_phase = PH_IDLE;
            end
        end
    end

    // Result toward the output register
    always_comb begin
        o_result.valid        = i_fire && (w_err || w_have_byte);
        o_result.decoded_byte = w_err ? 8'd0 : {r_high_nibble, w_nib};
        o_result.status       = w_err ? w_err_code : ST_DATA;
        o_result.last_result  = w_err || w_last;
    end

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_count_accum <= '0;
            r_count_ovf   <= 1'b0;
            r_bytes_left  <= '0;
            r_nibble_odd  <= 1'b0;
            r_high_nibble <= 4'd0;
        end else begin
            r_phase       <= n_phase;
            r_count_accum <= n_count_accum;
            r_count_ovf   <= n_count_ovf;
            r_bytes_left  <= n_bytes_left;
            r_nibble_odd  <= n_nibble_odd;
            r_high_nibble <= n_high_nibble;
        end
    end

    // Final byte or error always leaves the parser idle
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.last_result |=> r_phase == PH_IDLE)
        else $error("parser not idle after final result");

    // Decoding never runs with no bytes left
    a_data_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DATA |-> r_bytes_left != '0)
        else $error("data phase with zero bytes left");

    // Accumulated count stays within the bound
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {4'b0, r_count_accum} <= MAX_WIDE)
        else $error("byte count above bound");

endmodule

FILE: hw/rtl/hex_text_profile_decoder.sv
// A beat goes from the input register through the parser, and its result lands in the output register.
// Throughput: one character per cycle when not stalled; input refills while a result waits.
// The output register stalls only the input register, so one beat is held on backpressure.
// The parser step is a single pass of header, count and hex-pair logic per character.
// Reset (synchronous, active low) empties both registers and returns the parser to idle.
module hex_text_profile_decoder #(
    parameter int unsigned MAX_PROFILE_BYTES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    htpd_in_if.sink     i_in,
    htpd_out_if.source  o_out
);
    import htpd_pkg::*;

    logic    r_in_valid;
    t_beat   r_in_beat;
    logic    r_out_valid;
    t_result r_out;
    t_result w_result;
    logic    w_advance;
    logic    w_in_ready;

    // Pipeline flow: parse the held beat when the output register can take it
    assign w_advance  = !r_out_valid || o_out.ready;
    assign w_in_ready = !r_in_valid || w_advance;
    assign i_in.ready = w_in_ready;

    htpd_parser #(
        .MAX_PROFILE_BYTES(MAX_PROFILE_BYTES)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (r_in_valid && w_advance),
        .i_beat  (r_in_beat),
        .o_result(w_result)
    );

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_ready) begin
                r_in_valid <= i_in.valid;
            end
            if (w_advance) begin
                r_out_valid <= w_result.valid;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_in.valid && w_in_ready) begin
            r_in_beat.text_char   <= i_in.text_char;
            r_in_beat.first_char  <= i_in.first_char;
            r_in_beat.end_of_text <= i_in.end_of_text;
        end
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.decoded_byte = r_out.decoded_byte;
    assign o_out.status       = r_out.status;
    assign o_out.last_result  = r_out.last_result;

    // Error results carry last and a zero byte
    a_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.status != ST_DATA)
            |-> r_out.last_result && (r_out.decoded_byte == 8'd0))
        else $error("malformed error result");

    // A held beat is not dropped or changed while the output stalls
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_advance |=> r_in_valid && $stable(r_in_beat))
        else $error("held input beat lost");

endmodule
